FILE: rtl/core/prbsch_pkg.sv
// Shared types, codes and defaults for the process ready/block scheduler.
package prbsch_pkg;

	localparam int PID_WIDTH_DEF = 8;

	// Command codes
	localparam logic [1:0] CMD_CREATE    = 2'd0;
	localparam logic [1:0] CMD_TERMINATE = 2'd1;
	localparam logic [1:0] CMD_BLOCK     = 2'd2;
	localparam logic [1:0] CMD_WAKEUP    = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_IGNORED   = 2'd1;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] wake_pid;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] running_pid;
		logic       busy_res;
		logic [7:0] new_pid;
	} res_item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} prbsch_ctl_t;

endpackage

FILE: rtl/core/prbsch_ctrl.sv
// Controller: accept/execute sequencing and result valid.
module prbsch_ctrl
	import prbsch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	output logic        res_valid,
	input  logic        res_ready,
	output prbsch_ctl_t ctl
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   res_valid_q;

	assign cmd_ready   = (state_q == S_IDLE);
	assign res_valid   = res_valid_q;
	assign ctl.capture = cmd_valid && (state_q == S_IDLE);
	// result slot must be free (or freeing) before state commits
	assign ctl.execute = (state_q == S_EXEC) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ctl.execute) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctl.execute) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/prbsch_dp.sv
// Datapath: scheduler state, ready FIFO memory, blocked-mark memory, result register.
module prbsch_dp
	import prbsch_pkg::*;
#(
	parameter int PID_WIDTH = PID_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  prbsch_ctl_t ctl,
	input  cmd_item_t   cmd_data,
	output res_item_t   res_data
);

	localparam int DEPTH = 2 ** PID_WIDTH;
	localparam logic [PID_WIDTH:0] COUNT_FULL = {1'b1, {PID_WIDTH{1'b0}}};

	logic [PID_WIDTH-1:0] ready_mem [DEPTH];
	logic                 mark_mem  [DEPTH];

	logic [PID_WIDTH-1:0] last_pid_q, running_q, head_q, tail_q;
	logic [PID_WIDTH:0]   count_q;
	logic                 busy_q;

	logic [1:0]           cmd_s1;
	logic [PID_WIDTH-1:0] wake_s1;
	logic [PID_WIDTH-1:0] ready_rd_s1;
	logic                 mark_rd_s1;

	res_item_t res_q;

	logic [PID_WIDTH-1:0] wake_in;
	logic [PID_WIDTH-1:0] fresh;
	logic                 exhausted, wake_marked;
	logic [PID_WIDTH-1:0] last_pid_nxt, running_nxt, new_id;
	logic                 busy_nxt;
	logic [1:0]           status;
	logic                 push, pop, push_ok;
	logic [PID_WIDTH-1:0] push_id;
	logic                 mark_we, mark_din;
	logic [PID_WIDTH-1:0] mark_addr;
	logic                 queue_empty;

	assign wake_in     = PID_WIDTH'(cmd_data.wake_pid);
	assign fresh       = last_pid_q + PID_WIDTH'(1);
	assign exhausted   = (last_pid_q == {PID_WIDTH{1'b1}});
	assign queue_empty = (count_q == '0);
	// marks of ids not yet handed out were never written: treat as clear
	assign wake_marked = (wake_s1 != '0) && (wake_s1 <= last_pid_q) && mark_rd_s1;
	assign push_ok     = push && (count_q < COUNT_FULL);

	always_comb begin
		last_pid_nxt = last_pid_q;
		running_nxt  = running_q;
		busy_nxt     = busy_q;
		new_id       = '0;
		status       = STAT_DONE;
		push         = 1'b0;
		push_id      = '0;
		pop          = 1'b0;
		mark_we      = 1'b0;
		mark_addr    = '0;
		mark_din     = 1'b0;
		unique case (cmd_s1)
			CMD_CREATE: begin
				if (exhausted) begin
					status = STAT_EXHAUSTED;
				end else begin
					last_pid_nxt = fresh;
					new_id       = fresh;
					mark_we      = 1'b1;
					mark_addr    = fresh;
					mark_din     = 1'b0;
					if (!busy_q) begin
						running_nxt = fresh;
						busy_nxt    = 1'b1;
					end else begin
						push    = 1'b1;
						push_id = fresh;
					end
				end
			end
			CMD_TERMINATE: begin
				if (queue_empty) begin
					busy_nxt    = 1'b0;
					running_nxt = '0;
				end else begin
					running_nxt = ready_rd_s1;
					busy_nxt    = 1'b1;
					pop         = 1'b1;
				end
			end
			CMD_BLOCK: begin
				if (!busy_q) begin
					status = STAT_IGNORED;
				end else begin
					mark_we   = 1'b1;
					mark_addr = running_q;
					mark_din  = 1'b1;
					if (queue_empty) begin
						busy_nxt    = 1'b0;
						running_nxt = '0;
					end else begin
						running_nxt = ready_rd_s1;
						busy_nxt    = 1'b1;
						pop         = 1'b1;
					end
				end
			end
			CMD_WAKEUP: begin
				if (!wake_marked) begin
					status = STAT_IGNORED;
				end else begin
					mark_we   = 1'b1;
					mark_addr = wake_s1;
					mark_din  = 1'b0;
					if (!busy_q) begin
						running_nxt = wake_s1;
						busy_nxt    = 1'b1;
					end else begin
						push    = 1'b1;
						push_id = wake_s1;
					end
				end
			end
			default: begin
				status = STAT_DONE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pid_q <= '0;
			running_q  <= '0;
			busy_q     <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
		end else if (ctl.execute) begin
			last_pid_q <= last_pid_nxt;
			running_q  <= running_nxt;
			busy_q     <= busy_nxt;
			if (pop) begin
				head_q <= head_q + PID_WIDTH'(1);
			end
			if (push_ok) begin
				tail_q <= tail_q + PID_WIDTH'(1);
			end
			count_q <= count_q + (PID_WIDTH + 1)'(push_ok) - (PID_WIDTH + 1)'(pop);
		end
	end

	// Beat capture and registered memory reads
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_s1      <= cmd_data.command;
			wake_s1     <= wake_in;
			ready_rd_s1 <= ready_mem[head_q];
			mark_rd_s1  <= mark_mem[wake_in];
		end
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (ctl.execute && push_ok) begin
			ready_mem[tail_q] <= push_id;
		end
		if (ctl.execute && mark_we) begin
			mark_mem[mark_addr] <= mark_din;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			res_q.status      <= status;
			res_q.running_pid <= 8'(running_nxt);
			res_q.busy_res    <= busy_nxt;
			res_q.new_pid     <= 8'(new_id);
		end
	end

	assign res_data = res_q;

endmodule

FILE: rtl/core/process_ready_block_scheduler.sv
// Top level of the non-preemptive FIFO process scheduler with blocked marks.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  cmd     | in  | cmd_valid / cmd_ready | cmd_data: command, wake_pid
//  res     | out | res_valid / res_ready | res_data: status, running_pid, busy_res, new_pid
//
// For each command beat, the accept cycle issues the registered reads of the ready FIFO
// head and the blocked mark of wake_pid; the execute state then updates state, writes
// both memories and loads the result register once the result register is free.
// Reset needs no clearing pass: an id's mark is written when the id is created, and
// ids above the last one handed out read as not blocked.
// A result waiting on res_ready does not stop the next beat being accepted; that
// beat's update waits until the result register is free.
module process_ready_block_scheduler
	import prbsch_pkg::*;
#(
	parameter int PID_WIDTH = PID_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd_data,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_data
);

	prbsch_ctl_t ctl;

	prbsch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ctl       (ctl)
	);

	prbsch_dp #(
		.PID_WIDTH (PID_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd_data (cmd_data),
		.res_data (res_data)
	);

endmodule

FILE: test/tb_process_ready_block_scheduler.sv
`timescale 1ns / 1ps
// Testbench for the process ready/block scheduler: directed table, random commands, scoreboard.
module tb_process_ready_block_scheduler;
	import prbsch_pkg::*;

	localparam int DIR_ROWS = 23;
	localparam int RAND_ITEMS = 877;
	localparam int PID_LAST = 255;

	typedef struct packed {
		cmd_item_t item;
		logic      typed;
		res_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd_data = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res_data;

	// Scheduler shadow state
	logic [7:0] sch_last;
	logic [7:0] sch_run;
	logic       sch_busy;
	logic [7:0] rq_mem [256];
	logic [7:0] rq_head;
	logic [7:0] rq_tail;
	logic [8:0] rq_count;
	logic       blk_mark [256];

	res_item_t  exp_results [$];
	int         mismatches = 0;
	int         beats_checked = 0;
	logic       quiet = 1'b0;

	// Expected results are typed in only for the first four rows after reset
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{CMD_WAKEUP,    8'd0},   1'b1, '{STAT_IGNORED, 8'd0, 1'b0, 8'd0}},
		'{'{CMD_BLOCK,     8'hFF},  1'b1, '{STAT_IGNORED, 8'd0, 1'b0, 8'd0}},
		'{'{CMD_TERMINATE, 8'h55},  1'b1, '{STAT_DONE,    8'd0, 1'b0, 8'd0}},
		'{'{CMD_CREATE,    8'hAA},  1'b1, '{STAT_DONE,    8'd1, 1'b1, 8'd1}},
		'{'{CMD_CREATE,    8'hFF},  1'b0, '0},
		'{'{CMD_CREATE,    8'd0},   1'b0, '0},
		'{'{CMD_BLOCK,     8'd1},   1'b0, '0},
		'{'{CMD_WAKEUP,    8'd1},   1'b0, '0},
		'{'{CMD_WAKEUP,    8'd1},   1'b0, '0},
		'{'{CMD_WAKEUP,    8'hFF},  1'b0, '0},
		'{'{CMD_TERMINATE, 8'd0},   1'b0, '0},
		'{'{CMD_TERMINATE, 8'd0},   1'b0, '0},
		'{'{CMD_BLOCK,     8'd0},   1'b0, '0},
		'{'{CMD_BLOCK,     8'd0},   1'b0, '0},
		'{'{CMD_WAKEUP,    8'd1},   1'b0, '0},
		'{'{CMD_CREATE,    8'd0},   1'b0, '0},
		'{'{CMD_BLOCK,     8'd0},   1'b0, '0},
		'{'{CMD_BLOCK,     8'd0},   1'b0, '0},
		'{'{CMD_WAKEUP,    8'd4},   1'b0, '0},
		'{'{CMD_WAKEUP,    8'd1},   1'b0, '0},
		'{'{CMD_TERMINATE, 8'd0},   1'b0, '0},
		'{'{CMD_TERMINATE, 8'd0},   1'b0, '0},
		'{'{CMD_TERMINATE, 8'd0},   1'b0, '0}
	};

	process_ready_block_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void rq_push(logic [7:0] id);
		if (rq_count < 9'd256) begin
			rq_mem[rq_tail] = id;
			rq_tail = rq_tail + 8'd1;
			rq_count = rq_count + 9'd1;
		end
	endfunction

	// Hand the processor to the ready head, or go idle
	function automatic void rq_dispatch();
		if (rq_count == 9'd0) begin
			sch_busy = 1'b0;
			sch_run = 8'd0;
		end else begin
			sch_run = rq_mem[rq_head];
			rq_head = rq_head + 8'd1;
			rq_count = rq_count - 9'd1;
			sch_busy = 1'b1;
		end
	endfunction

	function automatic res_item_t sched_step(cmd_item_t c);
		res_item_t r;
		r = '0;
		r.status = STAT_DONE;
		case (c.command)
			CMD_CREATE: begin
				if (sch_last == 8'(PID_LAST)) begin
					r.status = STAT_EXHAUSTED;
				end else begin
					sch_last = sch_last + 8'd1;
					r.new_pid = sch_last;
					if (!sch_busy) begin
						sch_run = sch_last;
						sch_busy = 1'b1;
					end else begin
						rq_push(sch_last);
					end
				end
			end
			CMD_TERMINATE: begin
				rq_dispatch();
			end
			CMD_BLOCK: begin
				if (!sch_busy) begin
					r.status = STAT_IGNORED;
				end else begin
					blk_mark[sch_run] = 1'b1;
					rq_dispatch();
				end
			end
			default: begin
				if (!blk_mark[c.wake_pid]) begin
					r.status = STAT_IGNORED;
				end else begin
					blk_mark[c.wake_pid] = 1'b0;
					if (!sch_busy) begin
						sch_run = c.wake_pid;
						sch_busy = 1'b1;
					end else begin
						rq_push(c.wake_pid);
					end
				end
			end
		endcase
		r.running_pid = sch_run;
		r.busy_res = sch_busy;
		return r;
	endfunction

	// Random blocked id, 0 when none is blocked
	function automatic logic [7:0] pick_blocked();
		int n;
		int k;
		n = 0;
		for (int i = 0; i < 256; i++)
			if (blk_mark[i])
				n++;
		if (n == 0)
			return 8'd0;
		k = $urandom_range(0, n - 1);
		for (int i = 0; i < 256; i++) begin
			if (blk_mark[i]) begin
				if (k == 0)
					return 8'(i);
				k--;
			end
		end
		return 8'd0;
	endfunction

	task automatic flag_mismatch(string field, int got, int want);
		$display("mismatch on result %0d, %s: got %0d, want %0d",
			beats_checked, field, got, want);
		mismatches++;
	endtask

	// Drive one command beat and book its expected result on acceptance
	task automatic send_cmd(cmd_item_t item, logic typed, res_item_t want);
		res_item_t pred;
		while (!quiet && $urandom_range(0, 99) < 7) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= item;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		pred = sched_step(item);
		exp_results.push_back(typed ? want : pred);
	endtask

	always @(posedge clk) begin
		res_ready <= quiet || ($urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (exp_results.size() == 0) begin
				flag_mismatch("unexpected beat", 1, 0);
			end else begin
				want = exp_results.pop_front();
				if (res_data.status !== want.status)
					flag_mismatch("status", res_data.status, want.status);
				if (res_data.running_pid !== want.running_pid)
					flag_mismatch("running_pid", res_data.running_pid, want.running_pid);
				if (res_data.busy_res !== want.busy_res)
					flag_mismatch("busy_res", res_data.busy_res, want.busy_res);
				if (res_data.new_pid !== want.new_pid)
					flag_mismatch("new_pid", res_data.new_pid, want.new_pid);
			end
			beats_checked++;
		end
	end

	initial begin
		cmd_item_t item;
		int        pick;
		sch_last = 8'd0;
		sch_run = 8'd0;
		sch_busy = 1'b0;
		rq_head = 8'd0;
		rq_tail = 8'd0;
		rq_count = 9'd0;
		for (int i = 0; i < 256; i++) begin
			rq_mem[i] = 8'd0;
			blk_mark[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		// Creates weighted so the id space runs out part way through
		for (int i = 0; i < RAND_ITEMS; i++) begin
			quiet = (i >= 300 && i < 500);
			pick = $urandom_range(0, 99);
			item.wake_pid = 8'($urandom_range(0, 255));
			if (pick < 35) begin
				item.command = CMD_CREATE;
			end else if (pick < 55) begin
				item.command = CMD_TERMINATE;
			end else if (pick < 75) begin
				item.command = CMD_BLOCK;
			end else begin
				item.command = CMD_WAKEUP;
				if ($urandom_range(0, 99) < 75 && pick_blocked() != 8'd0)
					item.wake_pid = pick_blocked();
			end
			send_cmd(item, 1'b0, '0);
		end
		quiet = 1'b0;
		cmd_valid <= 1'b0;

		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
